// ===== hw/rtl/nfcp_pkg.sv =====
// Types, status codes and frame constants shared by the reply frame parser.
package nfcp_pkg;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START,
        PH_LEN,
        PH_LCS,
        PH_TFI,
        PH_PAYLOAD,
        PH_DCS,
        PH_POST,
        PH_ACK,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        ST_RESP_OK     = 3'd0,
        ST_ACK_OK      = 3'd1,
        ST_NOT_READY   = 3'd2,
        ST_BAD_START   = 3'd3,
        ST_BAD_LCS     = 3'd4,
        ST_BAD_TFI     = 3'd5,
        ST_ACK_MISMATCH = 3'd6,
        ST_EMPTY       = 3'd7
    } t_status;

    localparam logic [7:0] READY_BYTE = 8'h01;
    localparam logic [7:0] TFI_BYTE   = 8'hD5;
    localparam logic [2:0] START_LAST = 3'd2;
    localparam logic [2:0] ACK_LAST   = 3'd5;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       start_req;
        logic       expect_ack;
        logic [7:0] capacity;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_payload;
        logic [7:0] payload_count;
        logic [2:0] status;
        logic       last;
    } t_out;

    // Start code 00 00 FF, indexed by header position.
    function automatic logic [7:0] start_code(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd2:    v = 8'hFF;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // Acknowledge tail 00 00 FF 00 FF 00.
    function automatic logic [7:0] ack_tail(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd2, 3'd4: v = 8'hFF;
            default:    v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/nfcp_ctrl.sv =====
// Frame state machine: holds parse state and forms the result of each byte.
module nfcp_ctrl
    import nfcp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_acc,
    input  t_in  i_req,
    output logic o_res_valid,
    output t_out o_res
);

    t_phase     r_phase, n_phase;
    logic [2:0] r_hidx, n_hidx;
    logic [7:0] r_limit, n_limit;
    logic [7:0] r_len, n_len;
    logic [7:0] r_pidx, n_pidx;

    logic [7:0] b;
    logic [7:0] lcs_sum;
    logic [7:0] pidx_inc;

    assign b        = i_req.rx_byte;
    assign lcs_sum  = r_len + b;
    assign pidx_inc = r_pidx + 8'd1;

    // Next state.
    always_comb begin
        n_phase = r_phase;
        n_hidx  = r_hidx;
        n_limit = r_limit;
        n_len   = r_len;
        n_pidx  = r_pidx;
        if (i_acc) begin
            if (i_req.start_req) begin
                n_limit = i_req.capacity;
                n_hidx  = 3'd0;
                n_len   = 8'd0;
                n_pidx  = 8'd0;
                if (b != READY_BYTE) begin
                    n_phase = PH_DONE;
                end else begin
                    n_phase = i_req.expect_ack ? PH_ACK : PH_START;
                end
            end else begin
                case (r_phase)
                    PH_START: begin
                        if (b != start_code(r_hidx)) begin
                            n_phase = PH_DONE;
                        end else if (r_hidx == START_LAST) begin
                            n_hidx  = 3'd0;
                            n_phase = PH_LEN;
                        end else begin
                            n_hidx = r_hidx + 3'd1;
                        end
                    end
                    PH_LEN: begin
                        n_len   = b;
                        n_phase = PH_LCS;
                    end
                    PH_LCS: begin
                        if (lcs_sum != 8'd0 || r_len == 8'd0) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_len   = r_len - 8'd1;
                            n_phase = PH_TFI;
                        end
                    end
                    PH_TFI: begin
                        if (b != TFI_BYTE) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_pidx  = 8'd0;
                            n_phase = (r_len == 8'd0) ? PH_DCS : PH_PAYLOAD;
                        end
                    end
                    PH_PAYLOAD: begin
                        n_pidx = pidx_inc;
                        if (pidx_inc >= r_len) begin
                            n_phase = PH_DCS;
                        end
                    end
                    PH_DCS:  n_phase = PH_POST;
                    PH_POST: n_phase = PH_DONE;
                    PH_ACK: begin
                        if (b != ack_tail(r_hidx)) begin
                            n_phase = PH_DONE;
                        end else if (r_hidx == ACK_LAST) begin
                            n_hidx  = 3'd0;
                            n_phase = PH_DONE;
                        end else begin
                            n_hidx = r_hidx + 3'd1;
                        end
                    end
                    default: n_phase = r_phase;
                endcase
            end
        end
    end

    // Result of the current byte.
    always_comb begin
        o_res_valid         = 1'b0;
        o_res.out_byte      = 8'd0;
        o_res.is_payload    = 1'b0;
        o_res.payload_count = 8'd0;
        o_res.status        = ST_RESP_OK;
        o_res.last          = 1'b1;
        if (i_acc) begin
            if (i_req.start_req) begin
                o_res_valid  = (b != READY_BYTE);
                o_res.status = ST_NOT_READY;
            end else begin
                case (r_phase)
                    PH_START: begin
                        o_res_valid  = (b != start_code(r_hidx));
                        o_res.status = ST_BAD_START;
                    end
                    PH_LCS: begin
                        if (lcs_sum != 8'd0) begin
                            o_res_valid  = 1'b1;
                            o_res.status = ST_BAD_LCS;
                        end else if (r_len == 8'd0) begin
                            o_res_valid  = 1'b1;
                            o_res.status = ST_EMPTY;
                        end
                    end
                    PH_TFI: begin
                        o_res_valid         = (b != TFI_BYTE);
                        o_res.status        = ST_BAD_TFI;
                        o_res.payload_count = r_len;
                    end
                    PH_PAYLOAD: begin
                        o_res_valid      = (r_pidx < r_limit);
                        o_res.out_byte   = b;
                        o_res.is_payload = 1'b1;
                        o_res.last       = 1'b0;
                    end
                    PH_POST: begin
                        o_res_valid         = 1'b1;
                        o_res.payload_count = r_len;
                    end
                    PH_ACK: begin
                        if (b != ack_tail(r_hidx)) begin
                            o_res_valid  = 1'b1;
                            o_res.status = ST_ACK_MISMATCH;
                        end else if (r_hidx == ACK_LAST) begin
                            o_res_valid  = 1'b1;
                            o_res.status = ST_ACK_OK;
                        end
                    end
                    default: o_res_valid = 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_hidx  <= 3'd0;
            r_limit <= 8'd0;
            r_len   <= 8'd0;
            r_pidx  <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_hidx  <= n_hidx;
            r_limit <= n_limit;
            r_len   <= n_len;
            r_pidx  <= n_pidx;
        end
    end

endmodule

// ===== hw/rtl/nfc_reply_frame_parser_unit.sv =====
// Top level of the reader reply frame parser: handshake and result register.
// A result appears on the output in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless the input stalls; the parse state is updated in the same cycle.
// The input stalls only while the result register is full and stalled itself.
// Reset (synchronous, active low) returns the parser to idle with an empty
// result register; bytes without a start request are then ignored.
module nfc_reply_frame_parser_unit
    import nfcp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_req,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_res
);

    // The result register holds at most one result. A new request is taken
    // whenever that register is empty or is being drained in this cycle, so
    // bytes flow back to back while the consumer keeps up.
    logic r_out_valid;
    t_out r_out_res;
    logic in_acc;
    logic res_valid;
    t_out res;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_acc     = i_in_valid & ~o_in_stall;

    // The frame state machine updates its state on each accepted request and
    // says combinationally whether that byte yields a result.
    nfcp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (in_acc),
        .i_req       (i_in_req),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Load on a request that yields a result; otherwise clear when drained.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= res_valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload needs no reset; it is only looked at while valid is high.
    always_ff @(posedge i_clk) begin
        if (in_acc && res_valid) begin
            r_out_res <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

endmodule
